// File: hw/rtl/tdq_pkg.sv
package tdq_pkg;

	localparam int VAL_W          = 31;
	localparam int TICK_W         = 64;
	localparam int SUM_W          = 63;
	localparam int KIND_W         = 2;
	localparam int SLOT_W         = 4;
	localparam int FIRED_W        = 6;
	localparam int MAX_EXPIRIES   = 63;
	localparam int MAX_SLOTS_DEF  = 16;
	localparam int DELTA_BITS_DEF = 32;

	localparam logic [VAL_W-1:0]  VALUE_MAX = {VAL_W{1'b1}};
	localparam logic [TICK_W-1:0] TICK_ALL  = {TICK_W{1'b1}};
	localparam logic [TICK_W-1:0] SUM_CAP   = TICK_W'(1) << 62;

	typedef enum logic [KIND_W-1:0] {
		KIND_ARM      = 2'd0,
		KIND_DISARM   = 2'd1,
		KIND_ANNOUNCE = 2'd2,
		KIND_QUERY    = 2'd3
	} req_kind_t;

	typedef enum logic [KIND_W-1:0] {
		RES_ACK     = 2'd0,
		RES_EXPIRED = 2'd1,
		RES_REMAIN  = 2'd2,
		RES_NEXT    = 2'd3
	} res_kind_t;

	typedef enum logic {
		ALU_ADD_SAT   = 1'b0,
		ALU_SUB_CLAMP = 1'b1
	} alu_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ARM_D,
		ST_L_START,
		ST_L_CMP,
		ST_L_SUB,
		ST_L_PLACE,
		ST_L_PREV,
		ST_U_START,
		ST_U_CMP,
		ST_U_NX,
		ST_U_REL,
		ST_Q_START,
		ST_Q_ACC,
		ST_Q_SUB,
		ST_REM_OUT,
		ST_ACK,
		ST_A_HEAD,
		ST_A_CMP,
		ST_A_REM,
		ST_A_FIRE,
		ST_A_TICK,
		ST_A_EMIT,
		ST_A_PER,
		ST_A_TICK2,
		ST_NX_START,
		ST_NX_CALC,
		ST_NX_OUT
	} state_t;

endpackage

// File: hw/rtl/tdq_req_if.sv
interface tdq_req_if;
	import tdq_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [SLOT_W-1:0]  slot;
	logic [VAL_W-1:0]   delay_ticks;
	logic [VAL_W-1:0]   period_ticks;
	logic [VAL_W-1:0]   hw_elapsed;

	modport source (output valid, kind, slot, delay_ticks, period_ticks, hw_elapsed,
		input ready);
	modport sink (input valid, kind, slot, delay_ticks, period_ticks, hw_elapsed,
		output ready);
endinterface

// File: hw/rtl/tdq_rsp_if.sv
interface tdq_rsp_if;
	import tdq_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  result_kind;
	logic [SLOT_W-1:0]  slot_res;
	logic [VAL_W-1:0]   value;
	logic [TICK_W-1:0]  now_tick;
	logic               last;

	modport source (output valid, result_kind, slot_res, value, now_tick, last,
		input ready);
	modport sink (input valid, result_kind, slot_res, value, now_tick, last,
		output ready);
endinterface

// File: hw/rtl/tdq_alu.sv
module tdq_alu (
	input  tdq_pkg::alu_op_t            op,
	input  logic [tdq_pkg::TICK_W-1:0]  a,
	input  logic [tdq_pkg::TICK_W-1:0]  b,
	input  logic [tdq_pkg::TICK_W-1:0]  lim,
	output logic [tdq_pkg::TICK_W-1:0]  res,
	output logic                        gt
);
	import tdq_pkg::*;

	logic [TICK_W-1:0] sum;
	logic [TICK_W-1:0] diff;

	assign sum  = a + b;
	assign diff = a - b;
	assign gt   = a > b;

	always_comb begin
		case (op)
			ALU_ADD_SAT:   res = (sum > lim) ? lim : sum;
			ALU_SUB_CLAMP: res = gt ? diff : '0;
			default:       res = '0;
		endcase
	end
endmodule

// File: hw/rtl/tdq_store.sv
module tdq_store #(
	parameter int DEPTH = 16,
	parameter int W     = 32
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [$clog2(DEPTH)-1:0]  waddr,
	input  logic [W-1:0]              wdata,
	input  logic                      re,
	input  logic [$clog2(DEPTH)-1:0]  raddr,
	output logic [W-1:0]              rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: hw/rtl/timer_delta_queue.sv
// Timeout queue kept as a delta list over MAX_SLOTS timer slots. Each request beat (arm,
// disarm, query, announce) is processed alone; ready is low until its last response beat
// has been loaded. Requests walk the linked list in the slot memory, one entry read per
// step through a single read port, and the tick and delta adds and compares go through one
// shared 64-bit unit. An arm, disarm or query walks the list up to its slot's place; an
// announce fires the due head slots in order and walks the list again to reinsert each
// periodic slot. A stalled receiver holds the sequencer on each beat. Every request
// ends with a next-timeout beat carrying last. The slot memory needs no clearing after
// reset; the armed flags and the head-valid flag are cleared.
module timer_delta_queue #(
	parameter int MAX_SLOTS  = tdq_pkg::MAX_SLOTS_DEF,
	parameter int DELTA_BITS = tdq_pkg::DELTA_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	tdq_req_if.sink   req,
	tdq_rsp_if.source rsp
);
	import tdq_pkg::*;

	localparam int IW    = $clog2(MAX_SLOTS);
	localparam int SW    = (IW > SLOT_W) ? IW : SLOT_W;
	localparam int P_LO  = DELTA_BITS;
	localparam int L_LO  = DELTA_BITS + VAL_W;
	localparam int K_BIT = L_LO + IW;
	localparam int EW    = K_BIT + 1;
	localparam int GLIM  = 4 * MAX_SLOTS;
	localparam int GW    = $clog2(GLIM + 1);
	localparam logic [TICK_W-1:0] DMAX = TICK_W'({DELTA_BITS{1'b1}});

	function automatic logic [DELTA_BITS-1:0] e_delta(input logic [EW-1:0] e);
		return e[P_LO-1:0];
	endfunction
	function automatic logic [VAL_W-1:0] e_per(input logic [EW-1:0] e);
		return e[L_LO-1:P_LO];
	endfunction
	function automatic logic [IW-1:0] e_link(input logic [EW-1:0] e);
		return e[K_BIT-1:L_LO];
	endfunction
	function automatic logic [EW-1:0] e_pack(input logic ok, input logic [IW-1:0] lnk,
		input logic [VAL_W-1:0] per, input logic [DELTA_BITS-1:0] dl);
		return {ok, lnk, per, dl};
	endfunction
	function automatic logic [IW-1:0] to_idx(input logic [SLOT_W-1:0] s);
		logic [SW-1:0] w;
		w = SW'(s);
		return w[IW-1:0];
	endfunction
	function automatic logic [SLOT_W-1:0] to_slot(input logic [IW-1:0] i);
		logic [SW-1:0] w;
		w = SW'(i);
		return w[SLOT_W-1:0];
	endfunction
	function automatic logic [VAL_W-1:0] clamp_val(input logic [TICK_W-1:0] v);
		return (v > TICK_W'(VALUE_MAX)) ? VALUE_MAX : v[VAL_W-1:0];
	endfunction

	state_t state_q, state_d;

	logic [KIND_W-1:0]     kind_q, kind_d;
	logic [SLOT_W-1:0]     slot_q, slot_d;
	logic [VAL_W-1:0]      delay_q, delay_d;
	logic [VAL_W-1:0]      hw_q, hw_d;
	logic [VAL_W-1:0]      per_q, per_d;
	logic [IW-1:0]         head_q, head_d;
	logic                  head_ok_q, head_ok_d;
	logic [TICK_W-1:0]     tick_q, tick_d;
	logic [MAX_SLOTS-1:0]  armed_q, armed_d;
	logic [VAL_W-1:0]      pend_q, pend_d;
	logic [DELTA_BITS-1:0] d_q, d_d;
	logic [SUM_W-1:0]      sum_q, sum_d;
	logic [VAL_W-1:0]      rem_q, rem_d;
	logic [IW-1:0]         cur_q, cur_d;
	logic [IW-1:0]         prev_q, prev_d;
	logic                  prev_ok_q, prev_ok_d;
	logic                  have_q, have_d;
	logic [EW-1:0]         prev_ent_q, prev_ent_d;
	logic [EW-1:0]         sent_q, sent_d;
	logic [IW-1:0]         ins_q, ins_d;
	logic [IW-1:0]         h_q, h_d;
	logic [GW-1:0]         guard_q, guard_d;
	logic [FIRED_W-1:0]    fired_q, fired_d;
	logic                  ret_q, ret_d;

	logic                  out_valid_q;
	logic [KIND_W-1:0]     okind_q;
	logic [SLOT_W-1:0]     oslot_q;
	logic [VAL_W-1:0]      oval_q;
	logic [TICK_W-1:0]     onow_q;
	logic                  olast_q;
	logic                  out_load;
	logic [KIND_W-1:0]     okind_d;
	logic [SLOT_W-1:0]     oslot_d;
	logic [VAL_W-1:0]      oval_d;
	logic                  olast_d;
	logic                  out_free;

	alu_op_t               alu_op;
	logic [TICK_W-1:0]     alu_a, alu_b, alu_lim, alu_res;
	logic                  alu_gt;

	logic                  mem_we, mem_re;
	logic [IW-1:0]         mem_waddr, mem_raddr;
	logic [EW-1:0]         mem_wdata, rd;

	logic [IW-1:0]         req_idx;
	logic                  req_ok;

	tdq_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.lim (alu_lim),
		.res (alu_res),
		.gt  (alu_gt)
	);

	tdq_store #(
		.DEPTH (MAX_SLOTS),
		.W     (EW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd)
	);

	assign out_free = !out_valid_q || rsp.ready;
	assign req_idx  = to_idx(req.slot);
	assign req_ok   = 32'(req.slot) < MAX_SLOTS;

	assign rsp.valid       = out_valid_q;
	assign rsp.result_kind = okind_q;
	assign rsp.slot_res    = oslot_q;
	assign rsp.value       = oval_q;
	assign rsp.now_tick    = onow_q;
	assign rsp.last        = olast_q;

	always_comb begin
		state_d    = state_q;
		kind_d     = kind_q;
		slot_d     = slot_q;
		delay_d    = delay_q;
		hw_d       = hw_q;
		per_d      = per_q;
		head_d     = head_q;
		head_ok_d  = head_ok_q;
		tick_d     = tick_q;
		armed_d    = armed_q;
		pend_d     = pend_q;
		d_d        = d_q;
		sum_d      = sum_q;
		rem_d      = rem_q;
		cur_d      = cur_q;
		prev_d     = prev_q;
		prev_ok_d  = prev_ok_q;
		have_d     = have_q;
		prev_ent_d = prev_ent_q;
		sent_d     = sent_q;
		ins_d      = ins_q;
		h_d        = h_q;
		guard_d    = guard_q;
		fired_d    = fired_q;
		ret_d      = ret_q;
		out_load   = 1'b0;
		okind_d    = RES_ACK;
		oslot_d    = '0;
		oval_d     = '0;
		olast_d    = 1'b0;
		alu_op     = ALU_SUB_CLAMP;
		alu_a      = '0;
		alu_b      = '0;
		alu_lim    = DMAX;
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wdata  = '0;
		mem_re     = 1'b0;
		mem_raddr  = '0;
		req.ready  = 1'b0;

		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					kind_d  = req.kind;
					slot_d  = req.slot;
					delay_d = req.delay_ticks;
					hw_d    = req.hw_elapsed;
					per_d   = req.period_ticks;
					ins_d   = req_idx;
					case (req.kind)
						KIND_ARM: begin
							state_d = (req_ok && !armed_q[req_idx]) ? ST_ARM_D : ST_ACK;
						end
						KIND_DISARM: begin
							state_d = (req_ok && armed_q[req_idx]) ? ST_U_START : ST_ACK;
						end
						KIND_QUERY: begin
							rem_d   = '0;
							state_d = (req_ok && armed_q[req_idx]) ? ST_Q_START : ST_REM_OUT;
						end
						default: begin
							pend_d  = req.delay_ticks;
							fired_d = '0;
							guard_d = '0;
							state_d = ST_A_HEAD;
						end
					endcase
				end
			end

			ST_ARM_D: begin
				alu_op  = ALU_ADD_SAT;
				alu_a   = (delay_q == '0) ? TICK_W'(1) : TICK_W'(delay_q);
				alu_b   = TICK_W'(hw_q);
				d_d     = alu_res[DELTA_BITS-1:0];
				ret_d   = 1'b0;
				state_d = ST_L_START;
			end

			// ordered insert of ins_q with delta d_q
			ST_L_START: begin
				have_d    = 1'b0;
				prev_ok_d = 1'b0;
				if (head_ok_q) begin
					mem_re    = 1'b1;
					mem_raddr = head_q;
					cur_d     = head_q;
					state_d   = ST_L_CMP;
				end else begin
					state_d = ST_L_PLACE;
				end
			end

			ST_L_CMP: begin
				alu_a = TICK_W'(e_delta(rd));
				alu_b = TICK_W'(d_q);
				if (alu_gt) begin
					mem_we    = 1'b1;
					mem_waddr = cur_q;
					mem_wdata = e_pack(rd[K_BIT], e_link(rd), e_per(rd),
						alu_res[DELTA_BITS-1:0]);
					have_d    = 1'b1;
					state_d   = ST_L_PLACE;
				end else begin
					state_d = ST_L_SUB;
				end
			end

			ST_L_SUB: begin
				alu_a      = TICK_W'(d_q);
				alu_b      = TICK_W'(e_delta(rd));
				d_d        = alu_res[DELTA_BITS-1:0];
				prev_d     = cur_q;
				prev_ent_d = rd;
				prev_ok_d  = 1'b1;
				if (rd[K_BIT]) begin
					cur_d     = e_link(rd);
					mem_re    = 1'b1;
					mem_raddr = e_link(rd);
					state_d   = ST_L_CMP;
				end else begin
					have_d  = 1'b0;
					state_d = ST_L_PLACE;
				end
			end

			ST_L_PLACE: begin
				mem_we         = 1'b1;
				mem_waddr      = ins_q;
				mem_wdata      = e_pack(have_q, have_q ? cur_q : '0, per_q, d_q);
				armed_d[ins_q] = 1'b1;
				if (prev_ok_q) begin
					state_d = ST_L_PREV;
				end else begin
					head_d    = ins_q;
					head_ok_d = 1'b1;
					state_d   = ret_q ? ST_A_HEAD : ST_ACK;
				end
			end

			ST_L_PREV: begin
				mem_we    = 1'b1;
				mem_waddr = prev_q;
				mem_wdata = e_pack(1'b1, ins_q, e_per(prev_ent_q), e_delta(prev_ent_q));
				state_d   = ret_q ? ST_A_HEAD : ST_ACK;
			end

			// removal of ins_q, its delta credited to the successor
			ST_U_START: begin
				prev_ok_d = 1'b0;
				mem_re    = 1'b1;
				mem_raddr = head_q;
				cur_d     = head_q;
				state_d   = ST_U_CMP;
			end

			ST_U_CMP: begin
				if (cur_q == ins_q) begin
					sent_d = rd;
					if (rd[K_BIT]) begin
						mem_re    = 1'b1;
						mem_raddr = e_link(rd);
						cur_d     = e_link(rd);
						state_d   = ST_U_NX;
					end else begin
						state_d = ST_U_REL;
					end
				end else begin
					prev_d     = cur_q;
					prev_ent_d = rd;
					prev_ok_d  = 1'b1;
					if (rd[K_BIT]) begin
						mem_re    = 1'b1;
						mem_raddr = e_link(rd);
						cur_d     = e_link(rd);
					end else begin
						armed_d[ins_q] = 1'b0;
						state_d        = ST_ACK;
					end
				end
			end

			ST_U_NX: begin
				alu_op    = ALU_ADD_SAT;
				alu_a     = TICK_W'(e_delta(rd));
				alu_b     = TICK_W'(e_delta(sent_q));
				mem_we    = 1'b1;
				mem_waddr = cur_q;
				mem_wdata = e_pack(rd[K_BIT], e_link(rd), e_per(rd), alu_res[DELTA_BITS-1:0]);
				state_d   = ST_U_REL;
			end

			ST_U_REL: begin
				armed_d[ins_q] = 1'b0;
				if (prev_ok_q) begin
					mem_we    = 1'b1;
					mem_waddr = prev_q;
					mem_wdata = e_pack(sent_q[K_BIT], e_link(sent_q), e_per(prev_ent_q),
						e_delta(prev_ent_q));
				end else begin
					head_d    = e_link(sent_q);
					head_ok_d = sent_q[K_BIT];
				end
				state_d = ST_ACK;
			end

			// remaining ticks of a slot
			ST_Q_START: begin
				mem_re    = 1'b1;
				mem_raddr = head_q;
				cur_d     = head_q;
				sum_d     = '0;
				state_d   = ST_Q_ACC;
			end

			ST_Q_ACC: begin
				alu_op  = ALU_ADD_SAT;
				alu_a   = TICK_W'(sum_q);
				alu_b   = TICK_W'(e_delta(rd));
				alu_lim = SUM_CAP;
				sum_d   = alu_res[SUM_W-1:0];
				if (cur_q == ins_q || !rd[K_BIT]) begin
					state_d = ST_Q_SUB;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = e_link(rd);
					cur_d     = e_link(rd);
				end
			end

			ST_Q_SUB: begin
				alu_a   = TICK_W'(sum_q);
				alu_b   = TICK_W'(hw_q);
				rem_d   = clamp_val(alu_res);
				state_d = ST_REM_OUT;
			end

			ST_REM_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					okind_d  = RES_REMAIN;
					oslot_d  = slot_q;
					oval_d   = rem_q;
					state_d  = ST_NX_START;
				end
			end

			ST_ACK: begin
				if (out_free) begin
					out_load = 1'b1;
					okind_d  = RES_ACK;
					oslot_d  = slot_q;
					state_d  = ST_NX_START;
				end
			end

			// announce: fire due heads in order
			ST_A_HEAD: begin
				if (head_ok_q) begin
					mem_re    = 1'b1;
					mem_raddr = head_q;
					state_d   = ST_A_CMP;
				end else begin
					state_d = ST_A_TICK2;
				end
			end

			ST_A_CMP: begin
				alu_a = TICK_W'(e_delta(rd));
				alu_b = TICK_W'(pend_q);
				if (alu_gt || guard_q == GW'(GLIM)) begin
					state_d = ST_A_REM;
				end else begin
					state_d = ST_A_FIRE;
				end
			end

			ST_A_REM: begin
				alu_a     = TICK_W'(e_delta(rd));
				alu_b     = TICK_W'(pend_q);
				mem_we    = 1'b1;
				mem_waddr = head_q;
				mem_wdata = e_pack(rd[K_BIT], e_link(rd), e_per(rd), alu_res[DELTA_BITS-1:0]);
				state_d   = ST_A_TICK2;
			end

			ST_A_FIRE: begin
				alu_a           = TICK_W'(pend_q);
				alu_b           = TICK_W'(e_delta(rd));
				pend_d          = alu_res[VAL_W-1:0];
				h_d             = head_q;
				head_d          = e_link(rd);
				head_ok_d       = rd[K_BIT];
				armed_d[head_q] = 1'b0;
				state_d         = ST_A_TICK;
			end

			ST_A_TICK: begin
				alu_op  = ALU_ADD_SAT;
				alu_a   = tick_q;
				alu_b   = TICK_W'(e_delta(rd));
				alu_lim = TICK_ALL;
				tick_d  = alu_res;
				state_d = (fired_q < FIRED_W'(MAX_EXPIRIES)) ? ST_A_EMIT : ST_A_PER;
			end

			ST_A_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					okind_d  = RES_EXPIRED;
					oslot_d  = to_slot(h_q);
					fired_d  = fired_q + FIRED_W'(1);
					state_d  = ST_A_PER;
				end
			end

			ST_A_PER: begin
				guard_d = guard_q + GW'(1);
				if (e_per(rd) != '0) begin
					alu_op  = ALU_ADD_SAT;
					alu_a   = TICK_W'(e_per(rd));
					alu_b   = TICK_W'(pend_q);
					d_d     = alu_res[DELTA_BITS-1:0];
					per_d   = e_per(rd);
					ins_d   = h_q;
					ret_d   = 1'b1;
					state_d = ST_L_START;
				end else begin
					state_d = ST_A_HEAD;
				end
			end

			ST_A_TICK2: begin
				alu_op  = ALU_ADD_SAT;
				alu_a   = tick_q;
				alu_b   = TICK_W'(pend_q);
				alu_lim = TICK_ALL;
				tick_d  = alu_res;
				pend_d  = '0;
				state_d = ST_NX_START;
			end

			// next timeout beat
			ST_NX_START: begin
				if (head_ok_q) begin
					mem_re    = 1'b1;
					mem_raddr = head_q;
					state_d   = ST_NX_CALC;
				end else begin
					rem_d   = VALUE_MAX;
					state_d = ST_NX_OUT;
				end
			end

			ST_NX_CALC: begin
				alu_a   = TICK_W'(e_delta(rd));
				alu_b   = (kind_q == KIND_ANNOUNCE) ? '0 : TICK_W'(hw_q);
				rem_d   = clamp_val(alu_res);
				state_d = ST_NX_OUT;
			end

			ST_NX_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					okind_d  = RES_NEXT;
					oval_d   = rem_q;
					olast_d  = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_ok_q   <= 1'b0;
			tick_q      <= '0;
			armed_q     <= '0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_ok_q <= head_ok_d;
			tick_q    <= tick_d;
			armed_q   <= armed_d;
			pend_q    <= pend_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		kind_q     <= kind_d;
		slot_q     <= slot_d;
		delay_q    <= delay_d;
		hw_q       <= hw_d;
		per_q      <= per_d;
		head_q     <= head_d;
		d_q        <= d_d;
		sum_q      <= sum_d;
		rem_q      <= rem_d;
		cur_q      <= cur_d;
		prev_q     <= prev_d;
		prev_ok_q  <= prev_ok_d;
		have_q     <= have_d;
		prev_ent_q <= prev_ent_d;
		sent_q     <= sent_d;
		ins_q      <= ins_d;
		h_q        <= h_d;
		guard_q    <= guard_d;
		fired_q    <= fired_d;
		ret_q      <= ret_d;
		if (out_load) begin
			okind_q <= okind_d;
			oslot_q <= oslot_d;
			oval_q  <= oval_d;
			onow_q  <= tick_q;
			olast_q <= olast_d;
		end
	end
endmodule

// File: test/tb_timer_delta_queue.sv
module tb_timer_delta_queue;
	import tdq_pkg::*;

	localparam int NSLOT = 16;
	localparam logic [63:0] DELTA_CAP = (64'd1 << 32) - 64'd1;
	localparam int SETTLE = 200;

	typedef struct packed {
		res_kind_t         kind;
		logic [SLOT_W-1:0] slot;
		logic [VAL_W-1:0]  value;
		logic [TICK_W-1:0] now;
		logic              last;
	} timer_res_t;

	logic clk;
	logic arst_n;

	tdq_req_if req_ch();
	tdq_rsp_if rsp_ch();

	timer_delta_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// shadow of the delta list
	logic [63:0]       sh_delta[NSLOT];
	logic [VAL_W-1:0]  sh_period[NSLOT];
	logic [3:0]        sh_next[NSLOT];
	bit                sh_next_ok[NSLOT];
	bit                sh_armed[NSLOT];
	logic [3:0]        sh_head;
	bit                sh_head_ok;
	logic [63:0]       sh_tick;

	timer_res_t expected_beats[$];
	bit failed;
	int tx_idle_pct;
	int rx_idle_pct;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("** timer_delta_queue: FAILED **");
		$finish;
	end

	function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		return (s > DELTA_CAP) ? DELTA_CAP : s;
	endfunction

	function automatic void list_insert(int s, logic [63:0] d);
		bit have;
		bit prev_ok;
		int cur;
		int prev;
		int guard;
		have = sh_head_ok;
		prev_ok = 0;
		cur = sh_head;
		prev = 0;
		guard = 0;
		while (have && guard < NSLOT) begin
			if (sh_delta[cur] > d) begin
				sh_delta[cur] = sh_delta[cur] - d;
				break;
			end
			d = d - sh_delta[cur];
			prev = cur;
			prev_ok = 1;
			have = sh_next_ok[cur];
			cur = sh_next[cur];
			guard++;
		end
		if (guard >= NSLOT)
			have = 0;
		sh_delta[s] = d;
		sh_next_ok[s] = have;
		sh_next[s] = have ? cur[3:0] : 4'd0;
		if (prev_ok) begin
			sh_next[prev] = s[3:0];
			sh_next_ok[prev] = 1;
		end else begin
			sh_head = s[3:0];
			sh_head_ok = 1;
		end
		sh_armed[s] = 1;
	endfunction

	function automatic void list_remove(int s, bit credit);
		bit have;
		bit prev_ok;
		int cur;
		int prev;
		int guard;
		have = sh_head_ok;
		prev_ok = 0;
		cur = sh_head;
		prev = 0;
		guard = 0;
		while (have && guard < NSLOT && cur != s) begin
			prev = cur;
			prev_ok = 1;
			have = sh_next_ok[cur];
			cur = sh_next[cur];
			guard++;
		end
		sh_armed[s] = 0;
		if (!have || cur != s)
			return;
		if (credit && sh_next_ok[s])
			sh_delta[sh_next[s]] = add_sat(sh_delta[sh_next[s]], sh_delta[s]);
		if (prev_ok) begin
			sh_next_ok[prev] = sh_next_ok[s];
			sh_next[prev] = sh_next[s];
		end else begin
			sh_head_ok = sh_next_ok[s];
			sh_head = sh_next[s];
		end
		sh_next_ok[s] = 0;
	endfunction

	function automatic void push_beat(res_kind_t k, int s, logic [63:0] v, bit l);
		timer_res_t r;
		r.kind = k;
		r.slot = s[3:0];
		r.value = v[VAL_W-1:0];
		r.now = sh_tick;
		r.last = l;
		expected_beats.push_back(r);
	endfunction

	function automatic void predict_timer(req_kind_t k, int s, logic [63:0] dly,
		logic [63:0] per, logic [63:0] hw);
		logic [63:0] elapsed;
		logic [63:0] sum;
		logic [63:0] rem;
		logic [63:0] pend;
		logic [63:0] d;
		bit have;
		int cur;
		int guard;
		int fired;
		int h;
		elapsed = hw;
		case (k)
			KIND_ARM: begin
				if (!sh_armed[s]) begin
					sh_period[s] = per[VAL_W-1:0];
					list_insert(s, add_sat((dly != 0) ? dly : 64'd1, elapsed));
				end
				push_beat(RES_ACK, s, 0, 0);
			end
			KIND_DISARM: begin
				if (sh_armed[s])
					list_remove(s, 1);
				push_beat(RES_ACK, s, 0, 0);
			end
			KIND_QUERY: begin
				rem = 0;
				if (sh_armed[s]) begin
					sum = 0;
					have = sh_head_ok;
					cur = sh_head;
					guard = 0;
					while (have && guard < NSLOT) begin
						sum = sum + sh_delta[cur];
						if (sum > (64'd1 << 62))
							sum = 64'd1 << 62;
						if (cur == s)
							break;
						have = sh_next_ok[cur];
						cur = sh_next[cur];
						guard++;
					end
					rem = (sum > elapsed) ? sum - elapsed : 64'd0;
					if (rem > 64'(VALUE_MAX))
						rem = 64'(VALUE_MAX);
				end
				push_beat(RES_REMAIN, s, rem, 0);
			end
			default: begin
				pend = dly;
				fired = 0;
				guard = 0;
				while (sh_head_ok && sh_delta[sh_head] <= pend && guard < 4 * NSLOT) begin
					h = sh_head;
					d = sh_delta[h];
					sh_tick = sh_tick + d;
					pend = pend - d;
					list_remove(h, 0);
					if (fired < MAX_EXPIRIES) begin
						push_beat(RES_EXPIRED, h, 0, 0);
						fired++;
					end
					if (sh_period[h] != 0)
						list_insert(h, add_sat(64'(sh_period[h]), pend));
					guard++;
				end
				if (sh_head_ok)
					sh_delta[sh_head] = (sh_delta[sh_head] > pend) ?
						sh_delta[sh_head] - pend : 64'd0;
				sh_tick = sh_tick + pend;
				elapsed = 0;
			end
		endcase
		if (!sh_head_ok) begin
			d = 64'(VALUE_MAX);
		end else begin
			d = (sh_delta[sh_head] > elapsed) ? sh_delta[sh_head] - elapsed : 64'd0;
			if (d > 64'(VALUE_MAX))
				d = 64'(VALUE_MAX);
		end
		push_beat(RES_NEXT, 0, d, 1);
	endfunction

	// response checker
	always @(posedge clk) begin
		timer_res_t e;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_beats.size() == 0) begin
				$error("unexpected response beat kind=%0d slot=%0d", rsp_ch.result_kind,
					rsp_ch.slot_res);
				failed = 1;
			end else begin
				e = expected_beats.pop_front();
				if (rsp_ch.result_kind !== e.kind) begin
					$error("result_kind exp %0d got %0d", e.kind, rsp_ch.result_kind);
					failed = 1;
				end
				if (rsp_ch.slot_res !== e.slot) begin
					$error("slot_res exp %0d got %0d", e.slot, rsp_ch.slot_res);
					failed = 1;
				end
				if (rsp_ch.value !== e.value) begin
					$error("value exp %0d got %0d", e.value, rsp_ch.value);
					failed = 1;
				end
				if (rsp_ch.now_tick !== e.now) begin
					$error("now_tick exp %0d got %0d", e.now, rsp_ch.now_tick);
					failed = 1;
				end
				if (rsp_ch.last !== e.last) begin
					$error("last exp %0d got %0d", e.last, rsp_ch.last);
					failed = 1;
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);

	task automatic send_req(req_kind_t k, int s, logic [30:0] dly, logic [30:0] per,
		logic [30:0] hw);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct && gap < 40)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= k;
		req_ch.slot <= s[3:0];
		req_ch.delay_ticks <= dly;
		req_ch.period_ticks <= per;
		req_ch.hw_elapsed <= hw;
		predict_timer(k, s, 64'(dly), 64'(per), 64'(hw));
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task automatic drain_all();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [30:0] pick_ticks(int small_max);
		case ($urandom_range(9))
			0: return 31'($urandom);
			1: return VALUE_MAX;
			default: return 31'($urandom_range(small_max));
		endcase
	endfunction

	task automatic test_arm_extremes();
		send_req(KIND_ARM, 0, 0, 0, 0);
		send_req(KIND_ARM, 15, VALUE_MAX, VALUE_MAX, VALUE_MAX);
		send_req(KIND_ARM, 5, 31'h2AAAAAAA, 31'h55555555, 31'h2AAAAAAA);
		send_req(KIND_ARM, 5, 7, 0, 0);
		send_req(KIND_ARM, 7, 10, 3, 2);
		send_req(KIND_QUERY, 15, 0, 0, 0);
		send_req(KIND_QUERY, 7, 0, 0, VALUE_MAX);
		send_req(KIND_QUERY, 9, 0, 0, 0);
		send_req(KIND_DISARM, 5, 0, 0, 0);
		send_req(KIND_DISARM, 9, 0, 0, 0);
		send_req(KIND_ANNOUNCE, 0, 0, 0, 0);
		send_req(KIND_ANNOUNCE, 0, 40, 0, 0);
		send_req(KIND_ANNOUNCE, 0, VALUE_MAX, 0, 0);
		send_req(KIND_DISARM, 0, 0, 0, 0);
		send_req(KIND_DISARM, 7, 0, 0, 0);
		send_req(KIND_DISARM, 15, 0, 0, 0);
		send_req(KIND_ANNOUNCE, 0, 5, 0, 0);
	endtask

	task automatic test_expiry_saturation();
		for (int s = 0; s < NSLOT; s++)
			send_req(KIND_ARM, s, 1, 1, 0);
		send_req(KIND_ANNOUNCE, 0, 1000, 0, 0);
		drain_all();
		for (int s = 0; s < NSLOT; s++)
			send_req(KIND_DISARM, s, 0, 0, 0);
	endtask

	task automatic test_random_mix(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 35)
				send_req(KIND_ARM, $urandom_range(15), pick_ticks(60),
					($urandom_range(1) == 0) ? 31'd0 : pick_ticks(40), pick_ticks(8));
			else if (r < 55)
				send_req(KIND_DISARM, $urandom_range(15), 31'($urandom), 31'($urandom),
					31'($urandom));
			else if (r < 78)
				send_req(KIND_QUERY, $urandom_range(15), 31'($urandom), 31'($urandom),
					pick_ticks(20));
			else
				send_req(KIND_ANNOUNCE, $urandom_range(15), pick_ticks(50), 31'($urandom),
					31'($urandom));
			if (i == n / 2)
				drain_all();
		end
		drain_all();
	endtask

	initial begin
		failed = 0;
		tx_idle_pct = 28;
		rx_idle_pct = 88;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_ARM;
		req_ch.slot = '0;
		req_ch.delay_ticks = '0;
		req_ch.period_ticks = '0;
		req_ch.hw_elapsed = '0;
		rsp_ch.ready = 1'b0;
		for (int s = 0; s < NSLOT; s++) begin
			sh_armed[s] = 0;
			sh_next_ok[s] = 0;
			sh_delta[s] = 0;
			sh_period[s] = 0;
			sh_next[s] = 0;
		end
		sh_head = 0;
		sh_head_ok = 0;
		sh_tick = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_arm_extremes();
		drain_all();
		test_expiry_saturation();
		drain_all();
		test_random_mix(70);
		tx_idle_pct = 88;
		rx_idle_pct = 28;
		test_random_mix(70);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_mix(70);

		if (!failed && expected_beats.size() == 0)
			$display("** timer_delta_queue: PASSED **");
		else
			$display("** timer_delta_queue: FAILED **");
		$finish;
	end

endmodule
